// ===== rtl/hcb_pkg.sv =====
package hcb_pkg;

    typedef enum logic [1:0] {
        OP_RGB2HSV = 2'd0,
        OP_HSV2RGB = 2'd1,
        OP_LIGHTEN = 2'd2,
        OP_DARKEN  = 2'd3
    } op_t;

    localparam int IN_DW  = 72;
    localparam int OUT_DW = 56;

    localparam int DIV1_QW = 9;
    localparam int DIV2_QW = 8;

    localparam int ST_CAP  = 0;
    localparam int ST_NUM  = 1;
    localparam int ST_VSEL = 2;
    localparam int ST_D1   = 3;
    localparam int ST_HSV  = ST_D1 + DIV1_QW;
    localparam int ST_WRAP = ST_HSV + 1;
    localparam int ST_SEXT = ST_WRAP + 1;
    localparam int ST_MUL1 = ST_SEXT + 1;
    localparam int ST_MUL2 = ST_MUL1 + 1;
    localparam int ST_D2   = ST_MUL2 + 1;
    localparam int ST_OUT  = ST_D2 + DIV2_QW;
    localparam int NSTAGE  = ST_OUT + 1;

    localparam logic [15:0] PCT_UNIT  = 16'd100;
    localparam logic [23:0] LIGHT_SAT = 24'd51100;

    // 10000 / n for n in 1..99
    localparam logic [13:0] INV_PCT [100] = '{
        14'd0,    14'd10000, 14'd5000, 14'd3333, 14'd2500, 14'd2000, 14'd1666, 14'd1428,
        14'd1250, 14'd1111,  14'd1000, 14'd909,  14'd833,  14'd769,  14'd714,  14'd666,
        14'd625,  14'd588,   14'd555,  14'd526,  14'd500,  14'd476,  14'd454,  14'd434,
        14'd416,  14'd400,   14'd384,  14'd370,  14'd357,  14'd344,  14'd333,  14'd322,
        14'd312,  14'd303,   14'd294,  14'd285,  14'd277,  14'd270,  14'd263,  14'd256,
        14'd250,  14'd243,   14'd238,  14'd232,  14'd227,  14'd222,  14'd217,  14'd212,
        14'd208,  14'd204,   14'd200,  14'd196,  14'd192,  14'd188,  14'd185,  14'd181,
        14'd178,  14'd175,   14'd172,  14'd169,  14'd166,  14'd163,  14'd161,  14'd158,
        14'd156,  14'd153,   14'd151,  14'd149,  14'd147,  14'd144,  14'd142,  14'd140,
        14'd138,  14'd136,   14'd135,  14'd133,  14'd131,  14'd129,  14'd128,  14'd126,
        14'd125,  14'd123,   14'd121,  14'd120,  14'd119,  14'd117,  14'd116,  14'd114,
        14'd113,  14'd112,   14'd111,  14'd109,  14'd108,  14'd107,  14'd106,  14'd105,
        14'd104,  14'd103,   14'd102,  14'd101
    };

    typedef struct packed {
        op_t                op;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic signed [10:0] hue;
        logic [8:0]         sat;
        logic [8:0]         val;
        logic               pass;
        logic               lighten;
        logic               hz;
        logic [7:0]         mx;
        logic [7:0]         d;
        logic [8:0]         base;
        logic [7:0]         y;
        logic [15:0]        fac;
        logic [16:0]        s_num;
        logic [8:0]         s_den;
        logic [14:0]        h_num;
        logic [8:0]         h_den;
        logic [23:0]        prod;
        logic [14:0]        dk_num;
        logic [15:0]        v_num;
        logic [15:0]        v_den;
        logic [9:0]         out_hue;
        logic [7:0]         out_sat;
        logic [7:0]         out_val;
        logic               rej;
        logic signed [10:0] cv_h;
        logic [7:0]         cv_s;
        logic [7:0]         cv_v;
        logic               grey;
        logic [9:0]         hw;
        logic [2:0]         sx;
        logic [5:0]         f;
        logic [15:0]        pm;
        logic [13:0]        sf;
        logic [13:0]        st;
        logic [16:0]        p_num;
        logic [22:0]        q_num;
        logic [22:0]        t_num;
        logic [7:0]         out_red;
        logic [7:0]         out_green;
        logic [7:0]         out_blue;
    } item_t;

endpackage

// ===== rtl/hcb_div.sv =====
module hcb_div #(
    parameter int NW = 16,
    parameter int DW = 16,
    parameter int QW = 9
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [NW-1:0] rem_reg [QW-1];
    logic [DW-1:0] den_reg [QW-1];
    logic [QW-1:0] quo_reg [QW];

    genvar i;
    generate
        for (i = 0; i < QW; i++)
        begin : g_stage
            localparam int SH = QW - 1 - i;
            logic [NW-1:0] rem_in;
            logic [DW-1:0] den_in;
            logic [QW-1:0] quo_in;
            logic [CW-1:0] trial;
            logic          fits;
            logic [QW-1:0] quo_next;

            if (i == 0)
            begin : g_first
                assign rem_in = num;
                assign den_in = den;
                assign quo_in = '0;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[i-1];
                assign den_in = den_reg[i-1];
                assign quo_in = quo_reg[i-1];
            end

            assign trial    = CW'(den_in) << SH;
            assign fits     = CW'(rem_in) >= trial;
            assign quo_next = quo_in | (QW'(fits) << SH);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    quo_reg[i] <= quo_next;
                end
            end

            if (i < QW - 1)
            begin : g_keep
                logic [NW-1:0] rem_next;
                assign rem_next = fits ? rem_in - trial[NW-1:0] : rem_in;
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[i] <= rem_next;
                        den_reg[i] <= den_in;
                    end
                end
            end
        end
    endgenerate

    assign quo = quo_reg[QW-1];

endmodule

// ===== rtl/hsv_color_convert_and_brightness_top.sv =====
// Throughput: one transaction per cycle while the output is not stalled; set by
// the 26-stage pipeline with six restoring dividers of one quotient bit per stage.
// A stalled result freezes the whole pipeline and s_tready unless the stage
// ahead of the output is empty; only that one bubble is closed up.
// Reset (rst_n low, async) clears all valid bits; payload is not reset.
module hsv_color_convert_and_brightness_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // red, green, blue, hue, sat, val, factor, zero pad
    input  logic [hcb_pkg::IN_DW-1:0]    s_tdata,
    // op
    input  logic [1:0]                   s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // out_red, out_green, out_blue, out_hue, out_sat, out_val, zero pad
    output logic [hcb_pkg::OUT_DW-1:0]   m_tdata,
    // rejected
    output logic [0:0]                   m_tuser
);

    localparam int N = hcb_pkg::NSTAGE;

    hcb_pkg::item_t item_reg  [N];
    hcb_pkg::item_t item_next [N];
    logic [N-1:0]   vld_reg;
    logic [N-1:0]   vld_next;
    logic           core_en;
    logic           out_en;

    logic [hcb_pkg::DIV1_QW-1:0] sq_w;
    logic [hcb_pkg::DIV1_QW-1:0] hq_w;
    logic [hcb_pkg::DIV1_QW-1:0] vq_w;
    logic [hcb_pkg::DIV2_QW-1:0] pq_w;
    logic [hcb_pkg::DIV2_QW-1:0] qq_w;
    logic [hcb_pkg::DIV2_QW-1:0] tq_w;

    assign out_en   = !vld_reg[N-1] || m_tready;
    assign core_en  = out_en || !vld_reg[N-2];
    assign s_tready = core_en;

    hcb_div #(.NW(17), .DW(9), .QW(hcb_pkg::DIV1_QW)) u_div_sat (
        .clk (clk), .en (core_en),
        .num (item_reg[hcb_pkg::ST_VSEL].s_num), .den (item_reg[hcb_pkg::ST_VSEL].s_den),
        .quo (sq_w)
    );
    hcb_div #(.NW(15), .DW(9), .QW(hcb_pkg::DIV1_QW)) u_div_hue (
        .clk (clk), .en (core_en),
        .num (item_reg[hcb_pkg::ST_VSEL].h_num), .den (item_reg[hcb_pkg::ST_VSEL].h_den),
        .quo (hq_w)
    );
    hcb_div #(.NW(16), .DW(16), .QW(hcb_pkg::DIV1_QW)) u_div_val (
        .clk (clk), .en (core_en),
        .num (item_reg[hcb_pkg::ST_VSEL].v_num), .den (item_reg[hcb_pkg::ST_VSEL].v_den),
        .quo (vq_w)
    );
    hcb_div #(.NW(17), .DW(9), .QW(hcb_pkg::DIV2_QW)) u_div_p (
        .clk (clk), .en (core_en),
        .num (item_reg[hcb_pkg::ST_MUL2].p_num), .den (9'd510),
        .quo (pq_w)
    );
    hcb_div #(.NW(23), .DW(15), .QW(hcb_pkg::DIV2_QW)) u_div_q (
        .clk (clk), .en (core_en),
        .num (item_reg[hcb_pkg::ST_MUL2].q_num), .den (15'd30600),
        .quo (qq_w)
    );
    hcb_div #(.NW(23), .DW(15), .QW(hcb_pkg::DIV2_QW)) u_div_t (
        .clk (clk), .en (core_en),
        .num (item_reg[hcb_pkg::ST_MUL2].t_num), .den (15'd30600),
        .quo (tq_w)
    );

    always_comb
    begin
        logic [7:0]         r;
        logic [7:0]         g;
        logic [7:0]         b;
        logic [7:0]         mx;
        logic [7:0]         mn;
        logic [7:0]         d;
        logic [1:0]         w;
        logic [15:0]        fac_in;
        logic [8:0]         hsum;
        logic [7:0]         sq8;
        logic [8:0]         ex;
        logic [7:0]         sadj;
        logic [7:0]         vadj;
        logic [9:0]         hu;
        logic [9:0]         hw;
        logic [21:0]        qa;
        logic [21:0]        ta;
        logic [7:0]         cr;
        logic [7:0]         cg;
        logic [7:0]         cb;
        hcb_pkg::item_t     it;

        for (int k = 1; k < N; k++)
        begin
            item_next[k] = item_reg[k-1];
        end

        // capture: max, min, hue sextant
        r      = s_tdata[7:0];
        g      = s_tdata[15:8];
        b      = s_tdata[23:16];
        fac_in = s_tdata[68:53];
        mx = r;
        w  = 2'd0;
        if (g > mx)
        begin
            mx = g;
            w  = 2'd1;
        end
        if (b > mx)
        begin
            mx = b;
            w  = 2'd2;
        end
        mn = r;
        if (g < mn)
        begin
            mn = g;
        end
        if (b < mn)
        begin
            mn = b;
        end
        d = mx - mn;
        it = '0;
        it.op    = hcb_pkg::op_t'(s_tuser);
        it.red   = r;
        it.green = g;
        it.blue  = b;
        it.hue   = s_tdata[34:24];
        it.sat   = s_tdata[43:35];
        it.val   = s_tdata[52:44];
        it.mx    = mx;
        it.d     = d;
        it.hz    = (d == 8'd0);
        it.pass  = (fac_in == 16'd0);
        if (fac_in < hcb_pkg::PCT_UNIT)
        begin
            it.lighten = (it.op != hcb_pkg::OP_LIGHTEN);
            it.fac     = 16'(hcb_pkg::INV_PCT[fac_in[6:0]]);
        end
        else
        begin
            it.lighten = (it.op == hcb_pkg::OP_LIGHTEN);
            it.fac     = fac_in;
        end
        priority if (w == 2'd0)
        begin
            if (g >= b)
            begin
                it.base = 9'd0;
                it.y    = g - b;
            end
            else
            begin
                it.base = 9'd300;
                it.y    = 8'(9'(g) + 9'(d) - 9'(b));
            end
        end
        else if (w == 2'd1)
        begin
            if (b > r)
            begin
                it.base = 9'd120;
                it.y    = b - r;
            end
            else
            begin
                it.base = 9'd60;
                it.y    = 8'(9'(b) + 9'(d) - 9'(r));
            end
        end
        else
        begin
            if (r > g)
            begin
                it.base = 9'd240;
                it.y    = r - g;
            end
            else
            begin
                it.base = 9'd180;
                it.y    = 8'(9'(r) + 9'(d) - 9'(g));
            end
        end
        item_next[hcb_pkg::ST_CAP] = it;

        // numerators and denominators
        it = item_reg[hcb_pkg::ST_NUM-1];
        it.s_num  = 17'(it.d) * 17'd510 + 17'(it.mx);
        it.s_den  = {it.mx, 1'b0};
        it.h_num  = 15'(it.y) * 15'd120 + 15'(it.d);
        it.h_den  = {it.d, 1'b0};
        it.prod   = 24'(it.fac) * 24'(it.mx);
        it.dk_num = 15'(it.mx) * 15'd100;
        item_next[hcb_pkg::ST_NUM] = it;

        it = item_reg[hcb_pkg::ST_VSEL-1];
        if (it.lighten)
        begin
            it.v_num = (it.prod >= hcb_pkg::LIGHT_SAT) ? 16'(hcb_pkg::LIGHT_SAT) : it.prod[15:0];
            it.v_den = hcb_pkg::PCT_UNIT;
        end
        else
        begin
            it.v_num = 16'(it.dk_num);
            it.v_den = it.fac;
        end
        item_next[hcb_pkg::ST_VSEL] = it;

        // hsv assembly, brightness, range check
        it = item_reg[hcb_pkg::ST_HSV-1];
        hsum = it.base + 9'(hq_w[5:0]);
        sq8  = it.hz ? 8'd0 : sq_w[7:0];
        ex   = vq_w - 9'd255;
        it.out_hue = it.hz ? 10'h3FF : 10'(hsum);
        it.out_sat = sq8;
        it.out_val = it.mx;
        if (it.lighten && vq_w > 9'd255)
        begin
            sadj = (9'(sq8) > ex) ? 8'(9'(sq8) - ex) : 8'd0;
            vadj = 8'd255;
        end
        else
        begin
            sadj = sq8;
            vadj = vq_w[7:0];
        end
        if (it.op == hcb_pkg::OP_HSV2RGB)
        begin
            it.cv_h = it.hue;
            it.cv_s = it.sat[7:0];
            it.cv_v = it.val[7:0];
            it.rej  = ($signed(it.hue) < -11'sd1) || it.sat[8] || it.val[8];
        end
        else
        begin
            it.cv_h = it.hz ? -11'sd1 : $signed(11'(hsum));
            it.cv_s = sadj;
            it.cv_v = vadj;
            it.rej  = 1'b0;
        end
        item_next[hcb_pkg::ST_HSV] = it;

        it = item_reg[hcb_pkg::ST_WRAP-1];
        it.grey = (it.cv_s == 8'd0) || ($signed(it.cv_h) == -11'sd1);
        hu = it.cv_h[9:0];
        priority if (hu >= 10'd720)
        begin
            it.hw = hu - 10'd720;
        end
        else if (hu >= 10'd360)
        begin
            it.hw = hu - 10'd360;
        end
        else
        begin
            it.hw = hu;
        end
        item_next[hcb_pkg::ST_WRAP] = it;

        it = item_reg[hcb_pkg::ST_SEXT-1];
        hw = it.hw;
        priority if (hw < 10'd60)
        begin
            it.sx = 3'd0;
            it.f  = hw[5:0];
        end
        else if (hw < 10'd120)
        begin
            it.sx = 3'd1;
            it.f  = 6'(hw - 10'd60);
        end
        else if (hw < 10'd180)
        begin
            it.sx = 3'd2;
            it.f  = 6'(hw - 10'd120);
        end
        else if (hw < 10'd240)
        begin
            it.sx = 3'd3;
            it.f  = 6'(hw - 10'd180);
        end
        else if (hw < 10'd300)
        begin
            it.sx = 3'd4;
            it.f  = 6'(hw - 10'd240);
        end
        else
        begin
            it.sx = 3'd5;
            it.f  = 6'(hw - 10'd300);
        end
        item_next[hcb_pkg::ST_SEXT] = it;

        it = item_reg[hcb_pkg::ST_MUL1-1];
        it.pm = 16'(it.cv_v) * 16'(8'd255 - it.cv_s);
        it.sf = 14'(it.cv_s) * 14'(it.f);
        it.st = 14'(it.cv_s) * 14'(6'd60 - it.f);
        item_next[hcb_pkg::ST_MUL1] = it;

        it = item_reg[hcb_pkg::ST_MUL2-1];
        qa = 22'(it.cv_v) * 22'(15'd15300 - 15'(it.sf));
        ta = 22'(it.cv_v) * 22'(15'd15300 - 15'(it.st));
        it.p_num = {it.pm, 1'b0} + 17'd255;
        it.q_num = {qa, 1'b0} + 23'd15300;
        it.t_num = {ta, 1'b0} + 23'd15300;
        item_next[hcb_pkg::ST_MUL2] = it;

        // result select
        it = item_reg[hcb_pkg::ST_OUT-1];
        if (it.grey)
        begin
            cr = it.cv_v;
            cg = it.cv_v;
            cb = it.cv_v;
        end
        else
        begin
            unique case (it.sx)
                3'd0:
                begin
                    cr = it.cv_v; cg = tq_w; cb = pq_w;
                end
                3'd1:
                begin
                    cr = qq_w; cg = it.cv_v; cb = pq_w;
                end
                3'd2:
                begin
                    cr = pq_w; cg = it.cv_v; cb = tq_w;
                end
                3'd3:
                begin
                    cr = pq_w; cg = qq_w; cb = it.cv_v;
                end
                3'd4:
                begin
                    cr = tq_w; cg = pq_w; cb = it.cv_v;
                end
                default:
                begin
                    cr = it.cv_v; cg = pq_w; cb = qq_w;
                end
            endcase
        end
        it.out_red   = 8'd0;
        it.out_green = 8'd0;
        it.out_blue  = 8'd0;
        unique case (it.op)
            hcb_pkg::OP_RGB2HSV:
            begin
            end
            hcb_pkg::OP_HSV2RGB:
            begin
                it.out_hue = 10'd0;
                it.out_sat = 8'd0;
                it.out_val = 8'd0;
                if (!it.rej)
                begin
                    it.out_red   = cr;
                    it.out_green = cg;
                    it.out_blue  = cb;
                end
            end
            hcb_pkg::OP_LIGHTEN, hcb_pkg::OP_DARKEN:
            begin
                it.out_hue   = 10'd0;
                it.out_sat   = 8'd0;
                it.out_val   = 8'd0;
                it.out_red   = it.pass ? it.red   : cr;
                it.out_green = it.pass ? it.green : cg;
                it.out_blue  = it.pass ? it.blue  : cb;
            end
        endcase
        item_next[hcb_pkg::ST_OUT] = it;
    end

    always_comb
    begin
        vld_next[0] = core_en ? s_tvalid : vld_reg[0];
        for (int k = 1; k < N - 1; k++)
        begin
            vld_next[k] = core_en ? vld_reg[k-1] : vld_reg[k];
        end
        vld_next[N-1] = out_en ? vld_reg[N-2] : vld_reg[N-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N - 1; k++)
        begin
            if (core_en)
            begin
                item_reg[k] <= item_next[k];
            end
        end
        if (out_en)
        begin
            item_reg[N-1] <= item_next[N-1];
        end
    end

    assign m_tvalid = vld_reg[N-1];
    assign m_tdata  = {6'd0, item_reg[N-1].out_val, item_reg[N-1].out_sat,
                       item_reg[N-1].out_hue, item_reg[N-1].out_blue,
                       item_reg[N-1].out_green, item_reg[N-1].out_red};
    assign m_tuser  = item_reg[N-1].rej;

`ifndef SYNTH
    a_rej_only_hsv2rgb: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (item_reg[N-1].op == hcb_pkg::OP_HSV2RGB))
        else $error("rejected flag on non hsv2rgb transaction");

    a_rgb2hsv_no_rgb: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && item_reg[N-1].op == hcb_pkg::OP_RGB2HSV) |-> (m_tdata[23:0] == 24'd0))
        else $error("rgb2hsv transaction carries rgb");

    a_hsv_zero_other: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && item_reg[N-1].op != hcb_pkg::OP_RGB2HSV) |-> (m_tdata[49:24] == 26'd0))
        else $error("hsv fields set on non rgb2hsv transaction");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && item_reg[N-1].op == hcb_pkg::OP_RGB2HSV)
        |-> (m_tdata[33:24] == 10'h3FF || m_tdata[33:24] <= 10'd360))
        else $error("hue out of range");

    a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[N-1] && !m_tready) |=> (vld_reg[N-1] && $stable(item_reg[N-1])))
        else $error("output stage lost a stalled transaction");
`endif

endmodule
